// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define MAK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MAK_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MAK_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- rtl/mak_pkg.sv -----
`default_nettype none

package mak_pkg;

  localparam int ROUNDS = 10;
  localparam int IN_W   = 256;
  localparam int OUT_W  = 488;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_OPC_HIGH = 2'd2;
  localparam logic [1:0] REG_OPC_LOW  = 2'd3;

  // milenage constants c2..c5 in the last byte
  localparam logic [7:0] C_F2 = 8'h01;
  localparam logic [7:0] C_F3 = 8'h02;
  localparam logic [7:0] C_F4 = 8'h04;
  localparam logic [7:0] C_F5 = 8'h08;

  typedef enum logic [2:0] {
    OP_TEMP, OP_F2, OP_F3, OP_F4, OP_F5S, OP_F1, OP_F1S
  } op_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic step;
    logic last;
    logic store;
    logic finish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic mac_match;
    logic fresh;
  } stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // next round key, byte 0 in the top bits
  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rcon);
    logic [7:0] r [16];
    logic [7:0] n [16];
    logic [127:0] res;
    for (int i = 0; i < 16; i++) r[i] = rk[127 - 8*i -: 8];
    n[0] = r[0] ^ SBOX[r[13]] ^ rcon;
    n[1] = r[1] ^ SBOX[r[14]];
    n[2] = r[2] ^ SBOX[r[15]];
    n[3] = r[3] ^ SBOX[r[12]];
    for (int i = 4; i < 16; i++) n[i] = r[i] ^ n[i-4];
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = n[i];
    return res;
  endfunction

  // one aes round: subbytes, shiftrows, mixcolumns unless last, addroundkey
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last,
                                             input logic [127:0] rk);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i + 4*c] = SBOX[b[i + 4*((c + i) & 3)]];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = t[i] ^ rk[127 - 8*i -: 8];
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mak_dp.sv -----
`default_nettype none

`include "assert_macros.svh"

module mak_dp import mak_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [63:0]       cfg_wdata,
  input  wire logic [IN_W-1:0]   in_data,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  output logic      [OUT_W-1:0]  out_data
);

  logic [127:0] key, opc;
  logic [127:0] rand_in;
  logic [47:0]  sqnc_in, sqn, akstar, last_sqn;
  logic [15:0]  amf_in;
  logic [63:0]  mac_in, res, auts_mac;
  logic [127:0] temp, st, rk, ck, ik;
  logic [7:0]   rcon;
  logic         mac_ok;
  logic [127:0] aes_in, enc, x_opc, in1, rk_next;
  logic [63:0]  w;
  logic         fresh, resync;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      opc <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        REG_KEY_HIGH: key[127:64] <= cfg_wdata;
        REG_KEY_LOW:  key[63:0]   <= cfg_wdata;
        REG_OPC_HIGH: opc[127:64] <= cfg_wdata;
        REG_OPC_LOW:  opc[63:0]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input of the next encryption
  always_comb begin
    x_opc = temp ^ opc;
    w = (cmd.op == OP_F1S) ? {last_sqn, 16'h0000} : {sqn, amf_in};
    in1 = {w, w} ^ opc;
    case (cmd.op)
      OP_TEMP: aes_in = rand_in ^ opc;
      OP_F2:   aes_in = x_opc ^ {120'd0, C_F2};
      OP_F3:   aes_in = {x_opc[95:0], x_opc[127:96]} ^ {120'd0, C_F3};
      OP_F4:   aes_in = {x_opc[63:0], x_opc[127:64]} ^ {120'd0, C_F4};
      OP_F5S:  aes_in = {x_opc[31:0], x_opc[127:32]} ^ {120'd0, C_F5};
      default: aes_in = temp ^ {in1[63:0], in1[127:64]};
    endcase
  end

  assign rk_next = key_next(rk, rcon);
  assign enc     = st ^ opc;
  assign fresh   = sqn > last_sqn;
  assign resync  = mac_ok && !fresh;

  assign stat.mac_match = enc[127:64] == mac_in;
  assign stat.fresh     = fresh;

  // aes round unit, input capture, result stores, output register load
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rand_in <= {in_data[63:0], in_data[127:64]};
      sqnc_in <= in_data[175:128];
      amf_in  <= in_data[191:176];
      mac_in  <= in_data[255:192];
    end
    if (cmd.start) begin
      st   <= aes_in ^ key;
      rk   <= key;
      rcon <= 8'h01;
    end else if (cmd.step) begin
      st   <= aes_round(st, cmd.last, rk_next);
      rk   <= rk_next;
      rcon <= xtime(rcon);
    end
    if (cmd.store) begin
      case (cmd.op)
        OP_TEMP: temp <= st;
        OP_F2: begin
          sqn <= sqnc_in ^ enc[127:80];
          res <= enc[63:0];
        end
        OP_F3:  ck <= enc;
        OP_F4:  ik <= enc;
        OP_F5S: akstar <= enc[127:80];
        OP_F1:  mac_ok <= stat.mac_match;
        default: auts_mac <= enc[63:0];
      endcase
    end
    if (cmd.finish) begin
      out_data <= {6'd0,
                   resync ? auts_mac : 64'd0,
                   resync ? (last_sqn ^ akstar) : 48'd0,
                   ik[63:0], ik[127:64], ck[63:0], ck[127:64],
                   res, sqn, mac_ok && fresh, mac_ok};
    end
  end

  // stored sequence number
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sqn <= '0;
    end else if (cmd.finish && mac_ok && fresh) begin
      last_sqn <= sqn;
    end
  end

  `MAK_ASSERT_NEXT(a_sqn_hold, !cmd.finish, $stable(last_sqn), "last_sqn moved outside finish")
  `MAK_ASSERT_NEXT(a_sqn_take, cmd.finish && mac_ok && fresh, last_sqn == sqn, "fresh sqn not stored")

endmodule

`default_nettype wire

// ----- rtl/mak_ctrl.sv -----
`default_nettype none

`include "assert_macros.svh"

module mak_ctrl import mak_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  wire logic  m_tready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_ROUND, S_STORE, S_FIN} state_t;

  state_t     state;
  op_t        op;
  logic [3:0] rnd;

  assign s_tready = state == S_IDLE;

  // commands decoded from state
  always_comb begin
    cmd         = '0;
    cmd.op      = op;
    cmd.capture = s_tvalid && s_tready;
    cmd.start   = state == S_LOAD;
    cmd.step    = state == S_ROUND;
    cmd.last    = rnd == 4'(ROUNDS);
    cmd.store   = state == S_STORE;
    cmd.finish  = state == S_FIN && (!m_tvalid || m_tready);
  end

  // sequencer and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= OP_TEMP;
      rnd      <= 4'd1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !cmd.finish) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= OP_TEMP;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd   <= 4'd1;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 4'd1;
          if (rnd == 4'(ROUNDS)) state <= S_STORE;
        end
        S_STORE: begin
          case (op)
            OP_F1: begin
              if (stat.mac_match && !stat.fresh) begin
                op    <= OP_F1S;
                state <= S_LOAD;
              end else begin
                state <= S_FIN;
              end
            end
            OP_F1S: state <= S_FIN;
            default: begin
              op    <= op_t'(op + 3'd1);
              state <= S_LOAD;
            end
          endcase
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MAK_ASSERT_NEXT(a_fin_valid, cmd.finish, m_tvalid, "result not presented after finish")
  `MAK_ASSERT_NEXT(a_store_after, state == S_ROUND && rnd == 4'(ROUNDS), state == S_STORE, "store did not follow last round")
  `MAK_ASSERT(a_busy_ready, state != S_IDLE |-> !s_tready, "ready while busy")

endmodule

`default_nettype wire

// ----- rtl/milenage_aka_verify.sv -----
// MILENAGE AKA check over one iterative AES-128 unit that does one round per cycle with
// its key schedule computed on the fly. Each challenge runs six encryptions (TEMP, f2/f5,
// f3, f4, f5*, f1) and a seventh (f1*) when the MAC is good but SQN is stale; each goes
// through load, ten rounds and store. The result is then loaded into the output register;
// that load waits while an earlier result is not yet taken. A finished word waits in the
// output register; the next challenge is taken only once the sequencer is back in idle,
// not while the previous one is still in work. Key and OPc are written through the cfg
// port while the block is idle; the user must keep to this, as the block does not enforce it.
`default_nettype none

module milenage_aka_verify import mak_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wen,
  input  wire logic [1:0]        cfg_addr,
  input  wire logic [63:0]       cfg_wdata,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // rand_high, rand_low, sqn_concealed, amf_field, mac_received
  input  wire logic [IN_W-1:0]   s_tdata,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // mac_ok, sqn_ok, sqn_value, response, cipher_key_high, cipher_key_low,
  // integ_key_high, integ_key_low, auts_concealed, auts_mac, zero pad
  output logic      [OUT_W-1:0]  m_tdata
);

  cmd_t  cmd;
  stat_t stat;

  mak_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mak_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
